FILE: rtl/pben_pkg.sv
// ----------------------------------------------------------------------------
// pben_pkg
// Shared widths, register indexes, reset values, operation codes and the
// command/status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package pben_pkg;

  // Payload widths.
  localparam int BIN_W   = 9;
  localparam int POWER_W = 24;
  localparam int GAIN_W  = 16;
  localparam int ENV_W   = 17;

  // Trackers are Q24.16: the magnitude shifted left by P_SHIFT.
  localparam int P_SHIFT    = 16;
  localparam int TRK_W      = POWER_W + P_SHIFT;
  localparam int GATE_SHIFT = 8;
  localparam int PLO_W      = 2 * GAIN_W;

  // Quotient of the normalizing division.
  localparam int QUOT_W    = 16;
  localparam int DIV_CNT_W = $clog2(QUOT_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUOT_W - 1);

  localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(1 << QUOT_W);

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_GAIN      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_GAIN       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_WEIGHT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_RANGE        = 2'd3;

  localparam logic [GAIN_W-1:0]  ATTACK_GAIN_RST      = 16'd19661;
  localparam logic [GAIN_W-1:0]  DECAY_GAIN_RST       = 16'd66;
  localparam logic [GAIN_W-1:0]  THRESHOLD_WEIGHT_RST = 16'd1024;
  localparam logic [POWER_W-1:0] MIN_RANGE_RST        = 24'd1;

  // Operations of the shared multiplier.
  localparam logic [2:0] MUL_NONE  = 3'd0;
  localparam logic [2:0] MUL_GATE  = 3'd1;
  localparam logic [2:0] MUL_LO_HI = 3'd2;
  localparam logic [2:0] MUL_LO_LO = 3'd3;
  localparam logic [2:0] MUL_HI_HI = 3'd4;
  localparam logic [2:0] MUL_HI_LO = 3'd5;

  // Updates of the envelope register.
  localparam logic [1:0] ENV_HOLD = 2'd0;
  localparam logic [1:0] ENV_ZERO = 2'd1;
  localparam logic [1:0] ENV_NORM = 2'd2;
  localparam logic [1:0] ENV_QUOT = 2'd3;

  // Outcome of the range check.
  localparam logic [1:0] NORM_ZERO = 2'd0;
  localparam logic [1:0] NORM_ONE  = 2'd1;
  localparam logic [1:0] NORM_DIV  = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       clear_step;
    logic [2:0] mul_op;
    logic       check;
    logic       diff;
    logic       apply;
    logic       range_calc;
    logic       norm;
    logic       div_step;
    logic [1:0] env_op;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       gate_pass;
    logic       in_range;
    logic [1:0] norm_code;
    logic       out_busy;
  } status_t;

endpackage

FILE: rtl/pben_in_if.sv
// ----------------------------------------------------------------------------
// pben_in_if
// Input channel: one spectrum bin with its magnitude and noise floor.
// ----------------------------------------------------------------------------
interface pben_in_if import pben_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BIN_W-1:0]   bin_index;
  logic [POWER_W-1:0] bin_power;
  logic [POWER_W-1:0] noise_floor;

  modport source (output valid, output bin_index, output bin_power, output noise_floor,
                  input ready);
  modport sink (input valid, input bin_index, input bin_power, input noise_floor,
                output ready);
endinterface

FILE: rtl/pben_out_if.sv
// ----------------------------------------------------------------------------
// pben_out_if
// Result channel: gate decision and normalized envelope of one bin.
// ----------------------------------------------------------------------------
interface pben_out_if import pben_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             has_signal;
  logic [ENV_W-1:0] envelope;

  modport source (output valid, output has_signal, output envelope, input ready);
  modport sink (input valid, input has_signal, input envelope, output ready);
endinterface

FILE: rtl/pben_ram.sv
// ----------------------------------------------------------------------------
// pben_ram
// Generic single-port RAM with one write or read address and registered read.
// ----------------------------------------------------------------------------
module pben_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/pben_ctrl.sv
// ----------------------------------------------------------------------------
// pben_ctrl
// Sequencer: clearing pass, gate, tracker update through the shared
// multiplier, range check, serial division and result hand-off.
// ----------------------------------------------------------------------------
module pben_ctrl import pben_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_GATE   = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_DIFF   = 4'd4;
  localparam logic [3:0] S_MUL0   = 4'd5;
  localparam logic [3:0] S_MUL1   = 4'd6;
  localparam logic [3:0] S_MUL2   = 4'd7;
  localparam logic [3:0] S_MUL3   = 4'd8;
  localparam logic [3:0] S_APPLY  = 4'd9;
  localparam logic [3:0] S_RANGE  = 4'd10;
  localparam logic [3:0] S_NORM   = 4'd11;
  localparam logic [3:0] S_DIV    = 4'd12;
  localparam logic [3:0] S_FINISH = 4'd13;

  logic [3:0]           state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    cmd          = '0;
    state_next   = state;
    div_cnt_next = div_cnt;
    item_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = S_GATE;
        end
      end
      S_GATE: begin
        cmd.mul_op = MUL_GATE;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        cmd.env_op = ENV_ZERO;
        if (status.gate_pass && status.in_range) begin
          state_next = S_DIFF;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_op = MUL_LO_HI;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_op = MUL_LO_LO;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_op = MUL_HI_HI;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_op = MUL_HI_LO;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_RANGE;
      end
      S_RANGE: begin
        cmd.range_calc = 1'b1;
        state_next     = S_NORM;
      end
      S_NORM: begin
        cmd.norm     = 1'b1;
        cmd.env_op   = ENV_NORM;
        div_cnt_next = '0;
        if (status.norm_code == NORM_DIV) begin
          state_next = S_DIV;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) begin
          cmd.env_op = ENV_QUOT;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/pben_dp.sv
// ----------------------------------------------------------------------------
// pben_dp
// Datapath: configuration registers, tracker memories, shared 24x16
// multiplier, tracker update, range check, radix-2 divider, result register.
// ----------------------------------------------------------------------------
module pben_dp import pben_pkg::*; #(
  parameter int NUM_BINS = 512
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [BIN_W-1:0]       item_bin_index,
  input  logic [POWER_W-1:0]     item_bin_power,
  input  logic [POWER_W-1:0]     item_noise_floor,
  input  cmd_t                   cmd,
  output status_t                status,
  pben_out_if.source             result
);

  localparam int ADDR_W = $clog2(NUM_BINS);

  logic [GAIN_W-1:0]  attack_gain, decay_gain, threshold_weight;
  logic [POWER_W-1:0] min_range;

  logic [BIN_W-1:0]   bin;
  logic [POWER_W-1:0] power, floor_v;
  logic [TRK_W-1:0]   p;
  logic [ADDR_W-1:0]  bin_addr, clr_cnt, seed_addr;
  logic               gate_pass, in_range, seed_we, seeded_rd;
  logic [TRK_W-1:0]   lo_rd, hi_rd;

  logic [TRK_W-1:0]   lo, hi, dlo, dhi;
  logic               dir_lo, dir_hi;
  logic [GAIN_W-1:0]  gain_lo, gain_hi;

  logic [POWER_W-1:0] mul_a;
  logic [GAIN_W-1:0]  mul_b;
  logic [TRK_W-1:0]   mul_p, pa, pc;
  logic [PLO_W-1:0]   pb, pd;
  logic [TRK_W-1:0]   step_lo, step_hi;

  logic [TRK_W-1:0]   range_r, rem, r;
  logic               hi_gt_lo, p_le_lo, p_ge_hi;
  logic [1:0]         norm_code;
  logic [TRK_W:0]     div_shift, div_sub;
  logic               div_fit;
  logic [QUOT_W-1:0]  q, q_next;
  logic               sig;
  logic [ENV_W-1:0]   env;

  assign p        = {power, {P_SHIFT{1'b0}}};
  assign bin_addr = ADDR_W'(bin);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_gain      <= ATTACK_GAIN_RST;
      decay_gain       <= DECAY_GAIN_RST;
      threshold_weight <= THRESHOLD_WEIGHT_RST;
      min_range        <= MIN_RANGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTACK_GAIN:      attack_gain      <= cfg_data[GAIN_W-1:0];
        REG_DECAY_GAIN:       decay_gain       <= cfg_data[GAIN_W-1:0];
        REG_THRESHOLD_WEIGHT: threshold_weight <= cfg_data[GAIN_W-1:0];
        REG_MIN_RANGE:        min_range        <= cfg_data[POWER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bin     <= item_bin_index;
      power   <= item_bin_power;
      floor_v <= item_noise_floor;
    end
  end

  // Clearing pass over the seeded flags after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // The gate compares against the product left in pa by the gate multiply.
  assign gate_pass = (bin != '0) &&
                     ({{(TRK_W - POWER_W - GATE_SHIFT){1'b0}}, power,
                       {GATE_SHIFT{1'b0}}} >= pa);
  assign in_range  = 32'(bin) < NUM_BINS;

  assign seed_we   = cmd.clear_step || (cmd.check && gate_pass && in_range);
  assign seed_addr = cmd.clear_step ? clr_cnt : bin_addr;

  pben_ram #(.WIDTH(1), .DEPTH(NUM_BINS)) u_seeded (
    .clk   (clk),
    .we    (seed_we),
    .addr  (seed_addr),
    .wdata (!cmd.clear_step),
    .rdata (seeded_rd)
  );

  pben_ram #(.WIDTH(TRK_W), .DEPTH(NUM_BINS)) u_low (
    .clk   (clk),
    .we    (cmd.range_calc),
    .addr  (bin_addr),
    .wdata (lo),
    .rdata (lo_rd)
  );

  pben_ram #(.WIDTH(TRK_W), .DEPTH(NUM_BINS)) u_high (
    .clk   (clk),
    .we    (cmd.range_calc),
    .addr  (bin_addr),
    .wdata (hi),
    .rdata (hi_rd)
  );

  // Shared multiplier. A 40-bit distance is split into its upper 24 and
  // lower 16 bits; the scaled step is then upper product plus the top half
  // of the lower product.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_GATE: begin
        mul_a = floor_v;
        mul_b = threshold_weight;
      end
      MUL_LO_HI: begin
        mul_a = dlo[TRK_W-1:P_SHIFT];
        mul_b = gain_lo;
      end
      MUL_LO_LO: begin
        mul_a = POWER_W'(dlo[P_SHIFT-1:0]);
        mul_b = gain_lo;
      end
      MUL_HI_HI: begin
        mul_a = dhi[TRK_W-1:P_SHIFT];
        mul_b = gain_hi;
      end
      MUL_HI_LO: begin
        mul_a = POWER_W'(dhi[P_SHIFT-1:0]);
        mul_b = gain_hi;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    case (cmd.mul_op) inside
      MUL_GATE, MUL_LO_HI: pa <= mul_p;
      MUL_LO_LO:           pb <= mul_p[PLO_W-1:0];
      MUL_HI_HI:           pc <= mul_p;
      MUL_HI_LO:           pd <= mul_p[PLO_W-1:0];
      default: ;
    endcase
  end

  assign step_lo = pa + TRK_W'(pb[PLO_W-1:GAIN_W]);
  assign step_hi = pc + TRK_W'(pd[PLO_W-1:GAIN_W]);

  // Tracker registers: seed or load, distance, then the step toward p.
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      lo <= seeded_rd ? lo_rd : p;
      hi <= seeded_rd ? hi_rd : p;
    end else if (cmd.apply) begin
      lo <= dir_lo ? lo + step_lo : lo - step_lo;
      hi <= dir_hi ? hi + step_hi : hi - step_hi;
    end
    if (cmd.diff) begin
      dir_lo  <= p >= lo;
      dlo     <= (p >= lo) ? p - lo : lo - p;
      gain_lo <= (p < lo) ? attack_gain : decay_gain;
      dir_hi  <= p >= hi;
      dhi     <= (p >= hi) ? p - hi : hi - p;
      gain_hi <= (p > hi) ? attack_gain : decay_gain;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.range_calc) begin
      range_r  <= hi - lo;
      hi_gt_lo <= hi > lo;
      rem      <= p - lo;
      p_le_lo  <= p <= lo;
      p_ge_hi  <= p >= hi;
    end
  end

  always_comb begin
    if (!hi_gt_lo || (range_r < {min_range, {P_SHIFT{1'b0}}}) || p_le_lo) begin
      norm_code = NORM_ZERO;
    end else if (p_ge_hi) begin
      norm_code = NORM_ONE;
    end else begin
      norm_code = NORM_DIV;
    end
  end

  // Restoring division, one quotient bit per cycle; the remainder stays
  // below the range, so the doubled value fits one extra bit.
  assign div_shift = {r, 1'b0};
  assign div_fit   = div_shift >= {1'b0, range_r};
  assign div_sub   = div_shift - {1'b0, range_r};
  assign q_next    = {q[QUOT_W-2:0], div_fit};

  always_ff @(posedge clk) begin
    if (cmd.norm) begin
      r <= rem;
      q <= '0;
    end else if (cmd.div_step) begin
      r <= div_fit ? div_sub[TRK_W-1:0] : div_shift[TRK_W-1:0];
      q <= q_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      sig <= gate_pass;
    end
    case (cmd.env_op)
      ENV_ZERO: env <= '0;
      ENV_NORM: env <= (norm_code == NORM_ONE) ? ENV_ONE : '0;
      ENV_QUOT: env <= ENV_W'(q_next);
      default: ;
    endcase
  end

  // Result register: the next item may be worked on while this one waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.has_signal <= sig;
      result.envelope   <= env;
    end
  end

  assign status.clear_done = clr_cnt == ADDR_W'(NUM_BINS - 1);
  assign status.gate_pass  = gate_pass;
  assign status.in_range   = in_range;
  assign status.norm_code  = norm_code;
  assign status.out_busy   = result.valid && !result.ready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(result.valid && !result.ready))
    else $error("result loaded while the previous one was still waiting");

  a_trackers_bounded: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(cmd.apply) |->
      (dir_lo ? (lo <= p) : (lo >= p)) && (dir_hi ? (hi <= p) : (hi >= p)))
    else $error("tracker step passed the magnitude");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> r < range_r)
    else $error("divider remainder not below the range");

  a_env_legal: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.envelope <= ENV_ONE) &&
                     (result.has_signal || (result.envelope == '0)))
    else $error("envelope out of range or set without signal");

endmodule

FILE: rtl/per_bin_envelope_normalizer_top.sv
// ----------------------------------------------------------------------------
// per_bin_envelope_normalizer_top
// Per-bin peak/valley tracker that gates a bin against the noise floor and
// normalizes its magnitude into the tracked min-max range.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the per-bin seeded flags
// and takes no bin until it ends; configuration writes are taken at any
// time. Bins are handled one at a time. A bin that fails the gate, is bin
// zero or is not below NUM_BINS goes through the gate multiply and the gate
// check and then has its result loaded. A signal bin that needs the division
// goes through the distance, the four partial products of the single shared
// 24x16 multiplier (two per tracker), the tracker step, the range check and
// the radix-2 normalizing divider with its 16-bit quotient before its result
// is loaded; a signal bin whose envelope is settled by the range check skips
// the divider. A result still waiting in the output register when the next
// one is ready stalls the block until it is taken. The output register lets
// the next bin be accepted while the previous result waits to be taken.
module per_bin_envelope_normalizer_top import pben_pkg::*; #(
  parameter int NUM_BINS = 512
) (
  input  logic                   clk,
  input  logic                   rst,
  pben_in_if.sink                item,
  pben_out_if.source             result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t    cmd;
  status_t status;

  pben_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  pben_dp #(.NUM_BINS(NUM_BINS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item_bin_index   (item.bin_index),
    .item_bin_power   (item.bin_power),
    .item_noise_floor (item.noise_floor),
    .cmd              (cmd),
    .status           (status),
    .result           (result)
  );

endmodule

FILE: tb/per_bin_envelope_normalizer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_bin_envelope_normalizer_top_test
// Drives spectrum bins into the envelope normalizer under several register
// settings and random handshake pressure. A scoreboard keeps its own copy of
// the per-bin low/high trackers, predicts every result and checks each one
// in order as it is taken from the block.
// ----------------------------------------------------------------------------
module per_bin_envelope_normalizer_top_test;
  import pben_pkg::*;

  localparam int NUM_BINS         = 512;
  localparam int RANDOM_PER_PHASE = 255;
  localparam int NUM_PHASES       = 6;
  localparam int TOTAL_ITEMS      = 1547;
  localparam int STALL_LIMIT      = 5000;
  localparam int DRAIN_CYCLES     = 40;

  typedef struct packed {
    logic             has_signal;
    logic [ENV_W-1:0] envelope;
  } bin_result_t;

  class envelope_scoreboard;
    bit [GAIN_W-1:0]  attack_gain;
    bit [GAIN_W-1:0]  decay_gain;
    bit [GAIN_W-1:0]  threshold_weight;
    bit [POWER_W-1:0] min_range;
    bit [TRK_W-1:0]   low_trk[NUM_BINS];
    bit [TRK_W-1:0]   high_trk[NUM_BINS];
    bit               seeded[NUM_BINS];
    bin_result_t      expected_envelopes[$];
    int               errors;

    function new();
      attack_gain      = ATTACK_GAIN_RST;
      decay_gain       = DECAY_GAIN_RST;
      threshold_weight = THRESHOLD_WEIGHT_RST;
      min_range        = MIN_RANGE_RST;
      foreach (seeded[i]) seeded[i] = 1'b0;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_ATTACK_GAIN:      attack_gain      = value[GAIN_W-1:0];
        REG_DECAY_GAIN:       decay_gain       = value[GAIN_W-1:0];
        REG_THRESHOLD_WEIGHT: threshold_weight = value[GAIN_W-1:0];
        REG_MIN_RANGE:        min_range        = value[POWER_W-1:0];
        default: ;
      endcase
    endfunction

    // The step is truncated toward the tracker, so it never overshoots.
    function bit [63:0] step_toward(bit [63:0] trk, bit [63:0] target, bit [GAIN_W-1:0] gain);
      if (target >= trk) begin
        return trk + (((target - trk) * 64'(gain)) >> GAIN_W);
      end
      return trk - (((trk - target) * 64'(gain)) >> GAIN_W);
    endfunction

    function void note_bin(logic [BIN_W-1:0] bin, logic [POWER_W-1:0] power,
                           logic [POWER_W-1:0] noise);
      bin_result_t r;
      bit [63:0]   scaled;
      bit [63:0]   limit;
      bit [63:0]   p;
      bit [63:0]   lo;
      bit [63:0]   hi;
      bit [63:0]   span;
      bit [63:0]   numer;
      r = '0;
      scaled = 64'(power) << GATE_SHIFT;
      limit  = 64'(noise) * 64'(threshold_weight);
      r.has_signal = (bin != '0) && (scaled >= limit);
      if (r.has_signal && int'(bin) < NUM_BINS) begin
        p = 64'(power) << P_SHIFT;
        if (!seeded[bin]) begin
          low_trk[bin]  = p[TRK_W-1:0];
          high_trk[bin] = p[TRK_W-1:0];
          seeded[bin]   = 1'b1;
        end
        lo = 64'(low_trk[bin]);
        hi = 64'(high_trk[bin]);
        lo = step_toward(lo, p, (p < lo) ? attack_gain : decay_gain);
        hi = step_toward(hi, p, (p > hi) ? attack_gain : decay_gain);
        low_trk[bin]  = lo[TRK_W-1:0];
        high_trk[bin] = hi[TRK_W-1:0];
        // A low tracker above the high one counts as a range below the floor.
        if (hi > lo) begin
          span = hi - lo;
          if (span >= (64'(min_range) << P_SHIFT)) begin
            if (p <= lo) begin
              r.envelope = '0;
            end else if (p >= hi) begin
              r.envelope = ENV_ONE;
            end else begin
              numer = (p - lo) << QUOT_W;
              r.envelope = ENV_W'(numer / span);
            end
          end
        end
      end
      expected_envelopes.push_back(r);
    endfunction

    function void check_envelope(logic has_signal, logic [ENV_W-1:0] envelope);
      bin_result_t want;
      if (expected_envelopes.size() == 0) begin
        $display("%0t: unexpected result: has_signal %0d envelope %0d",
                 $time, has_signal, envelope);
        errors++;
        return;
      end
      want = expected_envelopes.pop_front();
      if (has_signal !== want.has_signal) begin
        $display("%0t: has_signal mismatch: expected %0d actual %0d",
                 $time, want.has_signal, has_signal);
        errors++;
      end
      if (envelope !== want.envelope) begin
        $display("%0t: envelope mismatch: expected %0d actual %0d",
                 $time, want.envelope, envelope);
        errors++;
      end
    endfunction

    function int pending();
      return expected_envelopes.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pben_in_if  item_bus ();
  pben_out_if result_bus ();

  per_bin_envelope_normalizer_top #(
    .NUM_BINS(NUM_BINS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_bus.sink),
    .result   (result_bus.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  envelope_scoreboard sb;
  int                 items_sent = 0;
  int                 quiet_cycles = 0;
  bit [POWER_W-1:0]   bin_level[NUM_BINS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender and receiver pressure moves through three stages over the run.
  function automatic int idle_pct(bit receiver_side);
    if (items_sent < TOTAL_ITEMS / 3) return receiver_side ? 56 : 38;
    if (items_sent < 2 * TOTAL_ITEMS / 3) return receiver_side ? 38 : 56;
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      sb.check_envelope(result_bus.has_signal, result_bus.envelope);
    end
  end

  // Ends the run when no transaction happens on either channel for too long.
  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("per_bin_envelope_normalizer_top test failed");
      $finish;
    end
  end

  // Valid stays high across back-to-back transactions; it drops only for a gap.
  task automatic send_bin(input logic [BIN_W-1:0] bin, input logic [POWER_W-1:0] power,
                          input logic [POWER_W-1:0] noise);
    if ($urandom_range(0, 99) < idle_pct(1'b0)) begin
      item_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct(1'b0));
    end
    item_bus.valid       <= 1'b1;
    item_bus.bin_index   <= bin;
    item_bus.bin_power   <= power;
    item_bus.noise_floor <= noise;
    do @(posedge clk); while (!item_bus.ready);
    sb.note_bin(bin, power, noise);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_register(index, value);
  endtask

  task automatic apply_setting(input logic [GAIN_W-1:0] attack, input logic [GAIN_W-1:0] decay,
                               input logic [GAIN_W-1:0] weight,
                               input logic [POWER_W-1:0] floor_range);
    write_reg(REG_ATTACK_GAIN, CFG_DATA_W'(attack));
    write_reg(REG_DECAY_GAIN, CFG_DATA_W'(decay));
    write_reg(REG_THRESHOLD_WEIGHT, CFG_DATA_W'(weight));
    write_reg(REG_MIN_RANGE, CFG_DATA_W'(floor_range));
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed(input int phase);
    case (phase)
      0: begin
        send_bin(9'd0, 24'hFFFFFF, 24'h000000);    // bin zero never gates in
        send_bin(9'd511, 24'hFFFFFF, 24'h000000);  // seeding gives a zero range
        send_bin(9'd511, 24'h000000, 24'h000000);
        send_bin(9'd511, 24'h800000, 24'h000000);
        send_bin(9'd1, 24'h000000, 24'hFFFFFF);
        send_bin(9'd1, 24'hFFFFFF, 24'h3FFFFF);
        send_bin(9'd2, 24'h000400, 24'h000100);    // gate met exactly
        send_bin(9'd3, 24'h000400, 24'h000101);    // one step short of the gate
        send_bin(9'd2, 24'h000100, 24'h000010);
      end
      1: begin
        // With no range floor, a flat bin must still yield zero.
        send_bin(9'd200, 24'h123456, 24'hFFFFFF);
        send_bin(9'd200, 24'h123456, 24'hFFFFFF);
        send_bin(9'd200, 24'h200000, 24'hFFFFFF);
        send_bin(9'd200, 24'h100000, 24'hFFFFFF);
        send_bin(9'd200, 24'h180000, 24'hFFFFFF);
      end
      2: begin
        // Decay above attack drives the low tracker past the high one.
        send_bin(9'd300, 24'd1000, 24'h000000);
        send_bin(9'd300, 24'd5000, 24'h000000);
        send_bin(9'd301, 24'hFFFFFF, 24'h000001);
      end
      default: ;
    endcase
  endtask

  function automatic void pick_random_bin(output logic [BIN_W-1:0] bin,
                                          output logic [POWER_W-1:0] power,
                                          output logic [POWER_W-1:0] noise);
    int        roll;
    bit [63:0] level;
    bit [63:0] wide;
    bit [63:0] pass_max;
    roll = $urandom_range(0, 99);
    if (roll < 5) bin = '0;
    else if (roll < 80) bin = BIN_W'($urandom_range(1, 24));
    else bin = BIN_W'($urandom_range(1, NUM_BINS - 1));

    if ($urandom_range(0, 9) == 0) begin
      power = POWER_W'($urandom);
    end else begin
      level = 64'(bin_level[bin]);
      wide  = (level >> 1) + 64'($urandom_range(0, int'(level)));
      power = (wide > 64'hFFFFFF) ? 24'hFFFFFF : wide[POWER_W-1:0];
    end

    // Place the noise floor mostly under the gate limit for this power.
    if (sb.threshold_weight == '0) pass_max = 64'hFFFFFF;
    else pass_max = (64'(power) << GATE_SHIFT) / 64'(sb.threshold_weight);
    if (pass_max > 64'hFFFFFF) pass_max = 64'hFFFFFF;
    roll = $urandom_range(0, 99);
    if (roll < 70 || pass_max == 64'hFFFFFF) begin
      noise = POWER_W'($urandom_range(0, int'(pass_max)));
    end else if (roll < 95) begin
      noise = POWER_W'($urandom_range(int'(pass_max) + 1, 24'hFFFFFF));
    end else begin
      noise = POWER_W'($urandom);
    end
  endfunction

  initial begin
    logic [BIN_W-1:0]   bin;
    logic [POWER_W-1:0] power;
    logic [POWER_W-1:0] noise;
    sb = new();
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    item_bus.valid       <= 1'b0;
    item_bus.bin_index   <= '0;
    item_bus.bin_power   <= '0;
    item_bus.noise_floor <= '0;
    foreach (bin_level[i]) begin
      bin_level[i] = POWER_W'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 16));
      if (bin_level[i] == '0) bin_level[i] = 24'd1;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: apply_setting(ATTACK_GAIN_RST, DECAY_GAIN_RST, THRESHOLD_WEIGHT_RST, MIN_RANGE_RST);
        1: apply_setting(16'hFFFF, 16'h0000, 16'h0000, 24'h000000);
        2: apply_setting(16'h0000, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        3: apply_setting(16'h8000, 16'h1000, 16'h0100, 24'h000100);
        4: apply_setting(GAIN_W'($urandom), GAIN_W'($urandom_range(0, 8191)),
                         GAIN_W'($urandom_range(0, 2047)),
                         POWER_W'($urandom_range(0, 4095)));
        default: apply_setting(16'd1000, 16'd20000, 16'h0300, 24'h000000);
      endcase
      run_directed(phase);
      repeat (RANDOM_PER_PHASE) begin
        pick_random_bin(bin, power, noise);
        send_bin(bin, power, noise);
      end
      item_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("per_bin_envelope_normalizer_top test passed");
    end else begin
      $display("per_bin_envelope_normalizer_top test failed");
    end
    $finish;
  end

endmodule

FILE: per_bin_envelope_normalizer_top.f
rtl/pben_pkg.sv
rtl/pben_in_if.sv
rtl/pben_out_if.sv
rtl/pben_ram.sv
rtl/pben_ctrl.sv
rtl/pben_dp.sv
rtl/per_bin_envelope_normalizer_top.sv
tb/per_bin_envelope_normalizer_top_test.sv
